// ===== hdl/pcf_pkg.sv =====
`default_nettype none
package pcf_pkg;

  localparam int MOD_W = 5;
  localparam int DEG_W = 2;
  localparam int IDX_W = 20;
  localparam int ROW_W = 10;
  localparam int PROD_W = 2 * MOD_W;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int DIV_BITS = 4;
  localparam int DIV_STEPS = IDX_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int MAX_MODULUS_DEF = 31;
  localparam int MAX_DEGREE_DEF = 3;

  localparam logic [MOD_W-1:0] MODULUS_RESET = MOD_W'(7);
  localparam logic [DEG_W-1:0] DEGREE_RESET = DEG_W'(2);

  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_DEGREE = 1'b1;

  typedef struct packed {
    logic load;
    logic div_step;
    logic pt_init;
    logic mul;
    logic red;
    logic emit;
  } pcf_cmd_t;

  typedef struct packed {
    logic div_last;
    logic dig_last;
    logic k_zero;
    logic i_zero;
    logic pt_last;
  } pcf_sts_t;

  function automatic logic [MOD_W-1:0] pcf_reduce(input logic [PROD_W-1:0] v,
                                                   input logic [MOD_W-1:0] q);
    logic [PROD_W:0] r;
    logic [PROD_W:0] d;
    r = {1'b0, v};
    for (int s = MOD_W; s >= 0; s--) begin
      d = (PROD_W + 1)'({1'b0, q}) << s;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[MOD_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/pcf_ctrl.sv =====
`default_nettype none
module pcf_ctrl
  import pcf_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  pcf_sts_t   sts,
  output pcf_cmd_t   cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_INIT = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_RED  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last && sts.dig_last) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.pt_init = 1'b1;
        state_nxt = sts.k_zero ? ST_EMIT : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_RED;
      end
      ST_RED: begin
        cmd.red = 1'b1;
        state_nxt = sts.i_zero ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = sts.pt_last ? ST_IDLE : ST_INIT;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

// ===== hdl/pcf_dp.sv =====
`default_nettype none
module pcf_dp
  import pcf_pkg::*;
#(
  parameter int MAX_MODULUS = MAX_MODULUS_DEF,
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  pcf_cmd_t          cmd,
  output pcf_sts_t          sts,
  input  wire [MOD_W-1:0]   modulus,
  input  wire [DEG_W-1:0]   degree,
  input  wire [IDX_W-1:0]   member_index,
  output logic              res_strobe,
  output logic [MOD_W-1:0]  res_eval_point,
  output logic [MOD_W-1:0]  res_poly_value,
  output logic [ROW_W-1:0]  res_group_row,
  output logic              res_last
);

  localparam int NCOEF = MAX_DEGREE + 1;
  localparam int DW = (NCOEF > 1) ? $clog2(NCOEF) : 1;

  logic [MOD_W-1:0]     q_eff;
  logic [DW-1:0]        k_eff;

  logic [MOD_W-1:0]     q_r;
  logic [DW-1:0]        k_r;
  logic [IDX_W-1:0]     rest_r;
  logic [MOD_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [DW-1:0]        dig_r;
  logic [MOD_W-1:0]     coef_r [NCOEF];
  logic [MOD_W-1:0]     x_r;
  logic [DW-1:0]        i_r;
  logic [MOD_W-1:0]     acc_r;
  logic [PROD_W-1:0]    prod_r;

  logic [MOD_W:0]       rem_nxt;
  logic [IDX_W-1:0]     quo_nxt;
  logic [DW-1:0]        rd_idx;
  logic [MOD_W-1:0]     coef_rd;
  logic                 div_last;

  always_comb begin
    q_eff = modulus;
    if (modulus < MOD_W'(2)) begin
      q_eff = MOD_W'(2);
    end else if (int'(modulus) > MAX_MODULUS) begin
      q_eff = MOD_W'(MAX_MODULUS);
    end
    if (int'(degree) > MAX_DEGREE) begin
      k_eff = DW'(MAX_DEGREE);
    end else begin
      k_eff = DW'(degree);
    end
  end

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    rem_nxt = {1'b0, rem_r};
    quo_nxt = rest_r;
    for (int b = 0; b < DIV_BITS; b++) begin
      rem_nxt = {rem_nxt[MOD_W-1:0], quo_nxt[IDX_W-1]};
      quo_nxt = {quo_nxt[IDX_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, q_r}) begin
        rem_nxt = rem_nxt - {1'b0, q_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  assign div_last = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign rd_idx = cmd.pt_init ? k_r : i_r - DW'(1);
  assign coef_rd = coef_r[rd_idx];

  assign sts.div_last = div_last;
  assign sts.dig_last = (dig_r == k_r);
  assign sts.k_zero = (k_r == '0);
  assign sts.i_zero = (i_r == '0);
  assign sts.pt_last = (x_r == q_r - MOD_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r <= q_eff;
      k_r <= k_eff;
      rest_r <= member_index;
      rem_r <= '0;
      div_cnt_r <= '0;
      dig_r <= '0;
      x_r <= '0;
    end
    if (cmd.div_step) begin
      rest_r <= quo_nxt;
      if (div_last) begin
        coef_r[dig_r] <= rem_nxt[MOD_W-1:0];
        rem_r <= '0;
        div_cnt_r <= '0;
        dig_r <= dig_r + DW'(1);
      end else begin
        rem_r <= rem_nxt[MOD_W-1:0];
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end
    end
    if (cmd.pt_init) begin
      acc_r <= coef_rd;
      i_r <= k_r;
    end
    if (cmd.mul) begin
      prod_r <= ({{MOD_W{1'b0}}, acc_r} * {{MOD_W{1'b0}}, x_r})
                + {{MOD_W{1'b0}}, coef_rd};
      i_r <= i_r - DW'(1);
    end
    if (cmd.red) begin
      acc_r <= pcf_reduce(prod_r, q_r);
    end
    if (cmd.emit) begin
      x_r <= x_r + MOD_W'(1);
      res_eval_point <= x_r;
      res_poly_value <= acc_r;
      res_group_row <= ({{MOD_W{1'b0}}, x_r} * {{MOD_W{1'b0}}, q_r})
                       + {{MOD_W{1'b0}}, acc_r};
      res_last <= (x_r == q_r - MOD_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= cmd.emit;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/polynomial_cover_free_group_map.sv =====
// Cover-free family column generator over the integers mod q.
// Input: pulse start with in_member_index while busy is low; the transaction
// is taken at that edge and busy rises on the next cycle.
// The low k+1 base-q digits of the index are the coefficients of p(x).
// Output: one transaction per point x = 0 .. q-1, in order, each shown for a
// single cycle with out_strobe; out_last marks x = q-1. The receiver cannot
// stall, so results must be taken as they appear.
// Steps: digit extraction runs k+1 divisions (four quotient bits a cycle in
// the shared divider), then each point runs an init step, one multiply-add
// and one reduction per Horner step, and an emit step.
// One item is processed at a time; the next may start on the cycle the last
// result is shown.
// Configuration: APB registers modulus (0x0) and degree (0x4), written by the
// user only while idle; the block itself does not enforce this. Reset returns
// q = 7, k = 2 and an idle block; no clearing pass.
`default_nettype none
module polynomial_cover_free_group_map
  import pcf_pkg::*;
#(
  parameter int MAX_MODULUS = MAX_MODULUS_DEF,
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire [IDX_W-1:0]     in_member_index,
  output logic                out_strobe,
  output logic [MOD_W-1:0]    out_eval_point,
  output logic [MOD_W-1:0]    out_poly_value,
  output logic [ROW_W-1:0]    out_group_row,
  output logic                out_last,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [PADDR_W-1:0]   paddr,
  input  wire [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  logic [MOD_W-1:0] cfg_modulus_r;
  logic [DEG_W-1:0] cfg_degree_r;
  logic             cfg_wr;
  pcf_cmd_t         cmd;
  pcf_sts_t         sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_modulus_r <= MODULUS_RESET;
      cfg_degree_r <= DEGREE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_MODULUS: cfg_modulus_r <= pwdata[MOD_W-1:0];
        REG_DEGREE:  cfg_degree_r <= pwdata[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODULUS: prdata = {{(PDATA_W-MOD_W){1'b0}}, cfg_modulus_r};
      REG_DEGREE:  prdata = {{(PDATA_W-DEG_W){1'b0}}, cfg_degree_r};
      default:     prdata = '0;
    endcase
  end

  pcf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  pcf_dp #(
    .MAX_MODULUS (MAX_MODULUS),
    .MAX_DEGREE  (MAX_DEGREE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .modulus        (cfg_modulus_r),
    .degree         (cfg_degree_r),
    .member_index   (in_member_index),
    .res_strobe     (out_strobe),
    .res_eval_point (out_eval_point),
    .res_poly_value (out_poly_value),
    .res_group_row  (out_group_row),
    .res_last       (out_last)
  );

endmodule
`default_nettype wire

// ===== hdl/pcf_chk.sv =====
`default_nettype none
module pcf_chk
  import pcf_pkg::*;
(
  input wire              clk,
  input wire              rst_n,
  input wire              start,
  input wire              busy,
  input wire              out_strobe,
  input wire [MOD_W-1:0]  out_eval_point,
  input wire [MOD_W-1:0]  out_poly_value,
  input wire [ROW_W-1:0]  out_group_row,
  input wire              out_last
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> !out_strobe)
    else $error("back-to-back result strobes");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> !busy)
    else $error("busy still high on final result");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !out_strobe |=> !out_strobe)
    else $error("result strobe with no transaction in flight");

  a_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_eval_point == '0) |->
      (out_group_row == {{(ROW_W-MOD_W){1'b0}}, out_poly_value}))
    else $error("group row wrong at point zero");

endmodule

bind polynomial_cover_free_group_map pcf_chk u_pcf_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_eval_point (out_eval_point),
  .out_poly_value (out_poly_value),
  .out_group_row  (out_group_row),
  .out_last       (out_last)
);
`default_nettype wire
